// ===== hdl/point_in_convex_polygon_macros.svh =====
// Assertion macros shared by the point-in-polygon checker
`ifndef POINT_IN_CONVEX_POLYGON_MACROS_SVH
`define POINT_IN_CONVEX_POLYGON_MACROS_SVH

// Check a consequent in the same cycle as the antecedent
`define PIPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after the antecedent
`define PIPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pipc_pkg.sv =====
// Package with widths, types and arithmetic helpers for the point-in-polygon test
`timescale 1ns / 1ps

package pipc_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int SUM_W      = 48;
    localparam int EXT_W      = (CROSS_W > SUM_W) ? CROSS_W : SUM_W;
    localparam int MARGIN_W   = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic [SUM_W-1:0]          sum_t;
    typedef logic [MARGIN_W-1:0]       margin_t;

    localparam sum_t SUM_MAX = {SUM_W{1'b1}};

    // One unit of back-end work: point, first vertex, edge (a,b) and flags
    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t fx;
        coord_t fy;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        logic   has_edge;
        logic   first;
        logic   last;
    } pipc_task_t;

    // Exact difference of two coordinates
    function automatic diff_t coord_diff(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    // Magnitude of a cross product, clipped to the sum width
    function automatic sum_t abs_clip(cross_t c);
        logic [CROSS_W-1:0] mag;
        logic [EXT_W-1:0]   wide;
        mag  = c[CROSS_W-1] ? CROSS_W'(-c) : CROSS_W'(c);
        wide = EXT_W'(mag);
        if (wide > EXT_W'(SUM_MAX))
            return SUM_MAX;
        else
            return wide[SUM_W-1:0];
    endfunction

    // Saturating add of two sums
    function automatic sum_t sat_add(sum_t a, sum_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ===== hdl/pipc_fifo.sv =====
// Short register queue that carries work items from the front end to the back end
`timescale 1ns / 1ps

module pipc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pipc_pkg::pipc_task_t wdata,
    output logic                full,
    input  logic                pop,
    output pipc_pkg::pipc_task_t rdata,
    output logic                not_empty
);
    import pipc_pkg::*;

    pipc_task_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    // Flag levels from the fill count
    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== hdl/pipc_front.sv =====
// Front end: accepts vertex items, tracks polygon state and issues edge work items
`timescale 1ns / 1ps

module pipc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pipc_pkg::coord_t     point_x,
    input  pipc_pkg::coord_t     point_y,
    input  pipc_pkg::coord_t     vertex_x,
    input  pipc_pkg::coord_t     vertex_y,
    input  logic                 last_vertex,
    input  logic                 fifo_full,
    output logic                 push,
    output pipc_pkg::pipc_task_t work
);
    import pipc_pkg::*;

    logic   in_poly_reg;
    coord_t held_x_reg;
    coord_t held_y_reg;
    coord_t first_x_reg;
    coord_t first_y_reg;
    coord_t prev_x_reg;
    coord_t prev_y_reg;

    assign in_ready = !fifo_full;
    assign push     = in_valid && in_ready;

    // Build the work item: the opening vertex carries the point and no edge
    always_comb
    begin
        work.px       = in_poly_reg ? held_x_reg  : point_x;
        work.py       = in_poly_reg ? held_y_reg  : point_y;
        work.fx       = in_poly_reg ? first_x_reg : vertex_x;
        work.fy       = in_poly_reg ? first_y_reg : vertex_y;
        work.ax       = prev_x_reg;
        work.ay       = prev_y_reg;
        work.bx       = vertex_x;
        work.by       = vertex_y;
        work.has_edge = in_poly_reg;
        work.first    = !in_poly_reg;
        work.last     = last_vertex;
    end

    // Update polygon state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_poly_reg <= 1'b0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else if (push)
        begin
            if (!in_poly_reg)
            begin
                held_x_reg  <= point_x;
                held_y_reg  <= point_y;
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
            end
            prev_x_reg  <= vertex_x;
            prev_y_reg  <= vertex_y;
            in_poly_reg <= !last_vertex;
        end
    end

endmodule

// ===== hdl/pipc_back.sv =====
// Back end: cross products, saturating accumulation, compare and result register
`timescale 1ns / 1ps

module pipc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 task_valid,
    input  pipc_pkg::pipc_task_t work,
    output logic                 task_pop,
    input  pipc_pkg::margin_t    margin,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 inside_res,
    output pipc_pkg::sum_t       point_area_sum,
    output pipc_pkg::sum_t       polygon_area_sum
);
    import pipc_pkg::*;

    logic   adv;

    // Stage 1: differences
    logic   s1_valid_reg;
    logic   s1_edge_reg;
    logic   s1_first_reg;
    logic   s1_last_reg;
    diff_t  pax_reg, pay_reg, pbx_reg, pby_reg;
    diff_t  fax_reg, fay_reg, fbx_reg, fby_reg;
    diff_t  pfx_reg, pfy_reg;

    // Stage 2: products
    logic   s2_valid_reg;
    logic   s2_edge_reg;
    logic   s2_first_reg;
    logic   s2_last_reg;
    prod_t  pe1_reg, pe2_reg, fe1_reg, fe2_reg, pc1_reg, pc2_reg;

    // Stage 3: signed cross products
    logic   s3_valid_reg;
    logic   s3_first_reg;
    logic   s3_last_reg;
    cross_t pe_reg, fe_reg, pc_reg;

    // Stage 4: clipped magnitudes
    logic   s4_valid_reg;
    logic   s4_first_reg;
    logic   s4_last_reg;
    sum_t   pe_abs_reg, fe_abs_reg, pc_abs_reg;

    // Stage 5: per-item terms
    logic   s5_valid_reg;
    logic   s5_first_reg;
    logic   s5_last_reg;
    sum_t   pt_term_reg, ft_term_reg;

    // Accumulators and finished sums
    sum_t   acc_pt_reg, acc_ft_reg;
    sum_t   acc_pt_next, acc_ft_next;
    logic   res_valid_reg;
    sum_t   res_pt_reg, res_ft_reg;

    // Output register
    logic   out_valid_reg;
    logic   inside_reg;
    sum_t   out_pt_reg, out_ft_reg;
    logic   inside_next;

    // Move the whole pipe unless a result is waiting to be taken
    assign adv      = !out_valid_reg || out_ready;
    assign task_pop = adv && task_valid;

    assign out_valid        = out_valid_reg;
    assign inside_res       = inside_reg;
    assign point_area_sum   = out_pt_reg;
    assign polygon_area_sum = out_ft_reg;

    // Restart on the opening vertex, otherwise add the term
    always_comb
    begin
        acc_pt_next = s5_first_reg ? pt_term_reg : sat_add(acc_pt_reg, pt_term_reg);
        acc_ft_next = s5_first_reg ? ft_term_reg : sat_add(acc_ft_reg, ft_term_reg);
    end

    // Compare at full precision with the margin added
    always_comb
    begin
        inside_next = ({1'b0, res_pt_reg} <=
                       ({1'b0, res_ft_reg} + (SUM_W + 1)'(margin)));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_pt_reg    <= '0;
            acc_ft_reg    <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= task_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            res_valid_reg <= s5_valid_reg && s5_last_reg;
            out_valid_reg <= res_valid_reg;
            if (s5_valid_reg)
            begin
                acc_pt_reg <= acc_pt_next;
                acc_ft_reg <= acc_ft_next;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: differences from the point and from the first vertex
            s1_edge_reg  <= work.has_edge;
            s1_first_reg <= work.first;
            s1_last_reg  <= work.last;
            pax_reg      <= coord_diff(work.px, work.ax);
            pay_reg      <= coord_diff(work.py, work.ay);
            pbx_reg      <= coord_diff(work.px, work.bx);
            pby_reg      <= coord_diff(work.py, work.by);
            fax_reg      <= coord_diff(work.fx, work.ax);
            fay_reg      <= coord_diff(work.fy, work.ay);
            fbx_reg      <= coord_diff(work.fx, work.bx);
            fby_reg      <= coord_diff(work.fy, work.by);
            pfx_reg      <= coord_diff(work.px, work.fx);
            pfy_reg      <= coord_diff(work.py, work.fy);

            // Stage 2: products for the edge and for the closing edge
            s2_edge_reg  <= s1_edge_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            pe1_reg      <= pax_reg * pby_reg;
            pe2_reg      <= pbx_reg * pay_reg;
            fe1_reg      <= fax_reg * fby_reg;
            fe2_reg      <= fbx_reg * fay_reg;
            pc1_reg      <= pbx_reg * pfy_reg;
            pc2_reg      <= pfx_reg * pby_reg;

            // Stage 3: drop terms for a missing edge; the closing edge adds
            // nothing to the first-vertex sum
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
            pe_reg       <= s2_edge_reg ? (cross_t'(pe1_reg) - cross_t'(pe2_reg)) : '0;
            fe_reg       <= s2_edge_reg ? (cross_t'(fe1_reg) - cross_t'(fe2_reg)) : '0;
            pc_reg       <= s2_last_reg ? (cross_t'(pc1_reg) - cross_t'(pc2_reg)) : '0;

            // Stage 4: magnitudes
            s4_first_reg <= s3_first_reg;
            s4_last_reg  <= s3_last_reg;
            pe_abs_reg   <= abs_clip(pe_reg);
            fe_abs_reg   <= abs_clip(fe_reg);
            pc_abs_reg   <= abs_clip(pc_reg);

            // Stage 5: fold the closing edge into the point term
            s5_first_reg <= s4_first_reg;
            s5_last_reg  <= s4_last_reg;
            pt_term_reg  <= sat_add(pe_abs_reg, pc_abs_reg);
            ft_term_reg  <= fe_abs_reg;

            // Capture finished sums, then the result
            res_pt_reg   <= acc_pt_next;
            res_ft_reg   <= acc_ft_next;
            inside_reg   <= inside_next;
            out_pt_reg   <= res_pt_reg;
            out_ft_reg   <= res_ft_reg;
        end
    end

endmodule

// ===== hdl/point_in_convex_polygon.sv =====
// Path: a last vertex item passes the queue, the back-end pipeline stages,
// the finished-sum register and the output register before its result shows.
// Throughput: one vertex item per cycle while the queue is not full. A stalled
// result holds the back pipe while the 4-entry queue takes items until full.
// Reset: asynchronous, active low; clears control state and the margin to 0.
// Top level of the point-in-convex-polygon area test
`timescale 1ns / 1ps

module point_in_convex_polygon (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pipc_pkg::coord_t        point_x,
    input  pipc_pkg::coord_t        point_y,
    input  pipc_pkg::coord_t        vertex_x,
    input  pipc_pkg::coord_t        vertex_y,
    input  logic                    last_vertex,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    inside_res,
    output pipc_pkg::sum_t          point_area_sum,
    output pipc_pkg::sum_t          polygon_area_sum,
    input  logic                    cfg_wr_en,
    input  pipc_pkg::margin_t       cfg_wr_data
);
    import pipc_pkg::*;

    margin_t    margin_reg;
    pipc_task_t front_work;
    pipc_task_t queue_head;
    logic       front_push;
    logic       queue_full;
    logic       queue_not_empty;
    logic       back_pop;

    // Hold the margin register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= '0;
        else if (cfg_wr_en)
            margin_reg <= cfg_wr_data;
    end

    pipc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .fifo_full   (queue_full),
        .push        (front_push),
        .work        (front_work)
    );

    pipc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .wdata     (front_work),
        .full      (queue_full),
        .pop       (back_pop),
        .rdata     (queue_head),
        .not_empty (queue_not_empty)
    );

    pipc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .task_valid       (queue_not_empty),
        .work             (queue_head),
        .task_pop         (back_pop),
        .margin           (margin_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .inside_res       (inside_res),
        .point_area_sum   (point_area_sum),
        .polygon_area_sum (polygon_area_sum)
    );

endmodule

// ===== hdl/pipc_checker.sv =====
// Port-level checker for the point-in-polygon block, bound to the top level
`timescale 1ns / 1ps
`include "point_in_convex_polygon_macros.svh"

module pipc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 inside_res,
    input pipc_pkg::sum_t       point_area_sum,
    input pipc_pkg::sum_t       polygon_area_sum
);
    import pipc_pkg::*;

    logic               out_stall;
    logic [2*SUM_W:0]   out_bundle;
    logic               zero_point;
    logic               sums_le;

    // Result-side conditions watched below
    assign out_stall  = out_valid && !out_ready;
    assign out_bundle = {inside_res, point_area_sum, polygon_area_sum};
    assign zero_point = out_valid && (point_area_sum == '0);
    assign sums_le    = out_valid && (point_area_sum <= polygon_area_sum);

    // A stalled result stays offered
    `PIPC_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `PIPC_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_bundle), "result changed while stalled")

    // A zero point sum is always inside
    `PIPC_ASSERT_SAME(a_zero_inside, zero_point, inside_res, "zero point sum reported outside")

    // A point sum no larger than the polygon sum is inside for any margin
    `PIPC_ASSERT_SAME(a_le_inside, sums_le, inside_res, "point sum within bound reported outside")

endmodule

bind point_in_convex_polygon pipc_checker u_pipc_checker (.*);
